@@ hw/rtl/sorted_list_priority_queue_unit_assert.svh @@
// assertion macros shared by the queue modules
`ifndef SORTED_LIST_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_LIST_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SLPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define SLPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define SLPQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLPQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/slpq_pkg.sv @@
`timescale 1ns / 1ps

package slpq_pkg;

	// queue geometry
	localparam int CAPACITY      = 16;
	localparam int DATA_BITS     = 32;
	localparam int PRIORITY_BITS = 8;
	localparam int CNT_BITS      = $clog2(CAPACITY + 1);
	localparam int OCC_BITS      = 5;
	localparam int STATUS_BITS   = 2;

	// operation codes
	typedef enum logic [0:0] {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_e_t;

	// result status codes
	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// output register occupancy
	typedef enum logic {
		OUT_EMPTY,
		OUT_HELD
	} out_state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    insert;
		logic    remove;
		status_t code;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

@@ hw/rtl/slpq_in_if.sv @@
`timescale 1ns / 1ps

interface slpq_in_if;
	logic                               valid;
	logic                               ready;
	logic                               operation;
	logic [slpq_pkg::DATA_BITS-1:0]     item_data;
	logic [slpq_pkg::PRIORITY_BITS-1:0] item_priority;

	modport source (output valid, operation, item_data, item_priority, input ready);
	modport sink (input valid, operation, item_data, item_priority, output ready);
endinterface

@@ hw/rtl/slpq_out_if.sv @@
`timescale 1ns / 1ps

interface slpq_out_if;
	logic                             valid;
	logic                             ready;
	logic [slpq_pkg::STATUS_BITS-1:0] status;
	logic [slpq_pkg::DATA_BITS-1:0]   out_data;
	logic                             queue_empty;
	logic [slpq_pkg::OCC_BITS-1:0]    occupancy;

	modport source (output valid, status, out_data, queue_empty, occupancy, input ready);
	modport sink (input valid, status, out_data, queue_empty, occupancy, output ready);
endinterface

@@ hw/rtl/slpq_datapath.sv @@
`timescale 1ns / 1ps
`include "sorted_list_priority_queue_unit_assert.svh"

module slpq_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  slpq_pkg::ctrl_cmd_t                cmd,
	input  logic [slpq_pkg::DATA_BITS-1:0]     item_data,
	input  logic [slpq_pkg::PRIORITY_BITS-1:0] item_priority,
	output slpq_pkg::dp_stat_t                 stat,
	output logic [slpq_pkg::STATUS_BITS-1:0]   status,
	output logic [slpq_pkg::DATA_BITS-1:0]     out_data,
	output logic                               queue_empty,
	output logic [slpq_pkg::OCC_BITS-1:0]      occupancy
);

	logic [slpq_pkg::DATA_BITS-1:0]     data_q [slpq_pkg::CAPACITY];
	logic [slpq_pkg::PRIORITY_BITS-1:0] prio_q [slpq_pkg::CAPACITY];
	logic [slpq_pkg::CNT_BITS-1:0]      count_q;
	logic [slpq_pkg::CNT_BITS-1:0]      count_next;
	logic [slpq_pkg::CAPACITY-1:0]      keep;

	// per-cell compare: cell stays put when it holds an entry of equal or higher priority
	always_comb begin
		for (int i = 0; i < slpq_pkg::CAPACITY; i++) begin
			keep[i] = (slpq_pkg::CNT_BITS'(i) < count_q) && (prio_q[i] >= item_priority);
		end
	end

	// list cells: insert shifts the tail right, remove shifts everything left
	for (genvar g = 0; g < slpq_pkg::CAPACITY; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.insert && !keep[g]) begin
				if (g == 0) begin
					data_q[g] <= item_data;
					prio_q[g] <= item_priority;
				end else if (keep[(g == 0) ? 0 : g - 1]) begin
					data_q[g] <= item_data;
					prio_q[g] <= item_priority;
				end else begin
					data_q[g] <= data_q[(g == 0) ? 0 : g - 1];
					prio_q[g] <= prio_q[(g == 0) ? 0 : g - 1];
				end
			end else if (cmd.remove && (g < slpq_pkg::CAPACITY - 1)) begin
				data_q[g] <= data_q[(g < slpq_pkg::CAPACITY - 1) ? g + 1 : g];
				prio_q[g] <= prio_q[(g < slpq_pkg::CAPACITY - 1) ? g + 1 : g];
			end
		end
	end

	// fill count
	always_comb begin
		count_next = count_q;
		if (cmd.insert) begin
			count_next = count_q + 1'b1;
		end else if (cmd.remove) begin
			count_next = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	assign stat.full  = (count_q == slpq_pkg::CNT_BITS'(slpq_pkg::CAPACITY));
	assign stat.empty = (count_q == '0);

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status      <= cmd.code;
			out_data    <= cmd.remove ? data_q[0] : '0;
			queue_empty <= (count_next == '0);
			occupancy   <= slpq_pkg::OCC_BITS'(count_next);
		end
	end

	`SLPQ_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= slpq_pkg::CNT_BITS'(slpq_pkg::CAPACITY))
	`SLPQ_ASSERT_NXT(a_insert_grows, clk, arst_n, cmd.insert, count_q == $past(count_q) + 1'b1)
	for (genvar k = 0; k < slpq_pkg::CAPACITY - 1; k++) begin : g_chk
		`SLPQ_ASSERT_IMP(a_sorted, clk, arst_n, slpq_pkg::CNT_BITS'(k + 1) < count_q, prio_q[k] >= prio_q[k + 1])
	end

endmodule

@@ hw/rtl/slpq_ctrl.sv @@
`timescale 1ns / 1ps
`include "sorted_list_priority_queue_unit_assert.svh"

module slpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_operation,
	input  logic                rsp_ready,
	input  slpq_pkg::dp_stat_t  stat,
	output logic                req_ready,
	output logic                rsp_valid,
	output slpq_pkg::ctrl_cmd_t cmd
);

	slpq_pkg::out_state_t state_q;
	slpq_pkg::out_state_t state_next;
	slpq_pkg::op_e_t      op;
	logic                 accept;

	assign op = slpq_pkg::op_e_t'(req_operation);

	// outputs and datapath commands
	always_comb begin
		req_ready  = (state_q == slpq_pkg::OUT_EMPTY) || rsp_ready;
		rsp_valid  = (state_q == slpq_pkg::OUT_HELD);
		accept     = req_valid && req_ready;
		cmd.load   = accept;
		cmd.insert = accept && (op == slpq_pkg::OP_ENQ) && !stat.full;
		cmd.remove = accept && (op == slpq_pkg::OP_DEQ) && !stat.empty;
		cmd.code   = slpq_pkg::ST_OK;
		if ((op == slpq_pkg::OP_ENQ) && stat.full) begin
			cmd.code = slpq_pkg::ST_FULL;
		end else if ((op == slpq_pkg::OP_DEQ) && stat.empty) begin
			cmd.code = slpq_pkg::ST_UNDERFLOW;
		end
	end

	// next state
	always_comb begin
		case (state_q)
			slpq_pkg::OUT_EMPTY: begin
				state_next = accept ? slpq_pkg::OUT_HELD : slpq_pkg::OUT_EMPTY;
			end
			slpq_pkg::OUT_HELD: begin
				if (accept || !rsp_ready) begin
					state_next = slpq_pkg::OUT_HELD;
				end else begin
					state_next = slpq_pkg::OUT_EMPTY;
				end
			end
			default: begin
				state_next = slpq_pkg::OUT_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slpq_pkg::OUT_EMPTY;
		end else begin
			state_q <= state_next;
		end
	end

	`SLPQ_ASSERT_NXT(a_accept_shows, clk, arst_n, accept, rsp_valid)
	`SLPQ_ASSERT_IMP(a_one_move, clk, arst_n, 1'b1, !(cmd.insert && cmd.remove))
	`SLPQ_ASSERT_IMP(a_no_move_on_error, clk, arst_n, cmd.code != slpq_pkg::ST_OK, !cmd.insert && !cmd.remove)

endmodule

@@ hw/rtl/sorted_list_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// Bounded priority queue of 16 entries kept as a list sorted by descending
// priority; equal priorities leave in arrival order.
// req channel: one word per operation, operation 0 enqueues item_data with
// item_priority, operation 1 dequeues the front entry.
// rsp channel: exactly one word per request with status (ok, underflow on an
// empty dequeue, full when an enqueue is dropped), the dequeued data (zero
// otherwise), the empty flag and the occupancy after the operation.
// The response word appears in the cycle after its request is taken.
// Throughput: one operation per cycle while the receiver takes each response;
// every list cell compares its priority with the new one in parallel and
// shifts in the same cycle.
// The response sits in an output register; a new request is taken while it
// is being read, and when the receiver stalls with a word held, req.ready is
// low until that word is taken.
// Reset empties the queue and the output register; list contents are not
// cleared, only the fill count.
module sorted_list_priority_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	slpq_in_if.sink     req,
	slpq_out_if.source  rsp
);

	slpq_pkg::ctrl_cmd_t cmd;
	slpq_pkg::dp_stat_t  stat;

	// sequencing of the handshake and the list commands
	slpq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_operation (req.operation),
		.rsp_ready     (rsp.ready),
		.stat          (stat),
		.req_ready     (req.ready),
		.rsp_valid     (rsp.valid),
		.cmd           (cmd)
	);

	// sorted list and result register
	slpq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item_data     (req.item_data),
		.item_priority (req.item_priority),
		.stat          (stat),
		.status        (rsp.status),
		.out_data      (rsp.out_data),
		.queue_empty   (rsp.queue_empty),
		.occupancy     (rsp.occupancy)
	);

endmodule
